// ----- sv/sensor_frame_checker_defines.svh -----
// ----------------------------------------------------------------------------
// Sensor frame checker assertion macros
// Shared property shorthands for the checker, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CHECKER_DEFINES_SVH
`define SENSOR_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SFC_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define SFC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor frame checker package
// Beat types, frame constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int MaxChunkDefault = 100;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  HDR_FIRST      = 8'h42;
    localparam logic [7:0]  HDR_SECOND     = 8'h4D;
    localparam logic [15:0] PART_LEN_FIELD = 16'd28;
    localparam int          GasLen         = 17;
    localparam int          PartLen        = 32;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_GAS      = 2'd1;
    localparam logic [1:0] KIND_PARTICLE = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } item_beat_t;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic        frame_valid;
        logic [15:0] co2_ppm;
        logic [15:0] tvoc_ppb;
        logic [15:0] hcho_ppb;
        logic [15:0] pm25_value;
    } result_beat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- sv/sfc_in_stage.sv -----
// ----------------------------------------------------------------------------
// Sensor frame checker input stage
// Registers one incoming beat and holds it until the frame logic takes it.
// ----------------------------------------------------------------------------
module sfc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sfc_pkg::item_beat_t item,
    input  logic              take,
    output logic              held_valid,
    output sfc_pkg::item_beat_t held
);
    import sfc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    item_beat_t beat_reg;

    assign item_ready = !valid_reg || take;
    assign valid_next = item_valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item_ready)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            beat_reg <= item;
    end

    assign held_valid = valid_reg;
    assign held       = beat_reg;

endmodule

// ----- sv/sfc_frame_acc.sv -----
// ----------------------------------------------------------------------------
// Sensor frame checker frame accumulator
// Tracks position, sum, CRC and captured bytes; forms the result at chunk end.
// ----------------------------------------------------------------------------
module sfc_frame_acc #(
    parameter int MAX_CHUNK = sfc_pkg::MaxChunkDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  sfc_pkg::item_beat_t  beat,
    output sfc_pkg::result_beat_t res
);
    import sfc_pkg::*;

    localparam int PosW = $clog2(MAX_CHUNK + 1);

    logic [PosW-1:0] pos_reg, pos_next;
    logic [15:0]     sum_reg, sum_next;
    logic [15:0]     crc_reg, crc_next;
    logic            hdr_reg, hdr_next;
    logic [15:0]     len_reg, len_next;
    logic [7:0]      fb_reg [6];
    logic [7:0]      fb_next [6];
    logic [15:0]     gchk_reg, gchk_next;
    logic [15:0]     pchk_reg, pchk_next;
    logic [2:0]      fb_idx;
    logic            active;
    logic            gas_ok;
    logic            part_ok;

    assign active = pos_reg < PosW'(MAX_CHUNK);
    assign fb_idx = 3'(pos_reg - PosW'(9));

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        crc_next  = crc_reg;
        hdr_next  = hdr_reg;
        len_next  = len_reg;
        fb_next   = fb_reg;
        gchk_next = gchk_reg;
        pchk_next = pchk_reg;
        if (active) begin
            if (pos_reg == PosW'(0))
                hdr_next = (beat.rx_byte == HDR_FIRST);
            else if (pos_reg == PosW'(1))
                hdr_next = hdr_reg && (beat.rx_byte == HDR_SECOND);
            else if (pos_reg == PosW'(2))
                len_next = {beat.rx_byte, 8'h00};
            else if (pos_reg == PosW'(3))
                len_next = {len_reg[15:8], beat.rx_byte};

            if (pos_reg < PosW'(30))
                sum_next = sum_reg + {8'h00, beat.rx_byte};
            if (pos_reg >= PosW'(2) && pos_reg <= PosW'(14))
                crc_next = crc_byte(crc_reg, beat.rx_byte);
            if (pos_reg >= PosW'(9) && pos_reg <= PosW'(14))
                fb_next[fb_idx] = beat.rx_byte;

            if (pos_reg == PosW'(15))
                gchk_next = {gchk_reg[15:8], beat.rx_byte};
            else if (pos_reg == PosW'(16))
                gchk_next = {beat.rx_byte, gchk_reg[7:0]};
            else if (pos_reg == PosW'(30))
                pchk_next = {beat.rx_byte, pchk_reg[7:0]};
            else if (pos_reg == PosW'(31))
                pchk_next = {pchk_reg[15:8], beat.rx_byte};

            pos_next = pos_reg + PosW'(1);
        end
    end

    assign gas_ok  = (crc_next == gchk_next);
    assign part_ok = hdr_next && (len_next == PART_LEN_FIELD) && (sum_next == pchk_next);

    always_comb
    begin
        res = '0;
        if (pos_next == PosW'(GasLen)) begin
            res.frame_kind  = KIND_GAS;
            res.frame_valid = gas_ok;
            if (gas_ok) begin
                res.co2_ppm  = {fb_next[0], fb_next[1]};
                res.tvoc_ppb = {fb_next[2], fb_next[3]};
                res.hcho_ppb = {fb_next[4], fb_next[5]};
            end
        end else if (pos_next == PosW'(PartLen)) begin
            res.frame_kind  = KIND_PARTICLE;
            res.frame_valid = part_ok;
            if (part_ok)
                res.pm25_value = {fb_next[3], fb_next[4]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            crc_reg  <= CRC_INIT;
            hdr_reg  <= 1'b0;
            len_reg  <= '0;
            fb_reg   <= '{default: '0};
            gchk_reg <= '0;
            pchk_reg <= '0;
        end else if (step) begin
            if (beat.chunk_end) begin
                pos_reg  <= '0;
                sum_reg  <= '0;
                crc_reg  <= CRC_INIT;
                hdr_reg  <= 1'b0;
                len_reg  <= '0;
                fb_reg   <= '{default: '0};
                gchk_reg <= '0;
                pchk_reg <= '0;
            end else begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                crc_reg  <= crc_next;
                hdr_reg  <= hdr_next;
                len_reg  <= len_next;
                fb_reg   <= fb_next;
                gchk_reg <= gchk_next;
                pchk_reg <= pchk_next;
            end
        end
    end

endmodule

// ----- sv/sfc_out_stage.sv -----
// ----------------------------------------------------------------------------
// Sensor frame checker output stage
// Result register that holds a frame report until the consumer takes it.
// ----------------------------------------------------------------------------
module sfc_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  sfc_pkg::result_beat_t res,
    output logic                  free,
    output logic                  result_valid,
    input  logic                  result_ready,
    output sfc_pkg::result_beat_t result
);
    import sfc_pkg::*;

    logic         valid_reg;
    result_beat_t res_reg;

    assign free = !valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

// ----- sv/sensor_frame_checker.sv -----
// ----------------------------------------------------------------------------
// Sensor frame checker
// Checks and decodes gas and particle sensor frames received byte by byte.
//
//   channel  direction  payload          beat carries
//   item     in         item_beat_t      one UART byte and its chunk end flag
//   result   out        result_beat_t    frame kind, validity and values
//
// One byte is taken per cycle unless a chunk end byte waits on a stalled result.
// The byte register, the frame logic and the result register form the path.
// Reset clears position and sum and presets the CRC; a result only waits in its register.
// A stalled result holds back only a chunk end byte; others keep flowing.
// ----------------------------------------------------------------------------
module sensor_frame_checker #(
    parameter int MAX_CHUNK = sfc_pkg::MaxChunkDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  sfc_pkg::item_beat_t   item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output sfc_pkg::result_beat_t result
);
    import sfc_pkg::*;

    logic         held_valid;
    item_beat_t   held;
    logic         out_free;
    logic         step;
    result_beat_t res;

    assign step = held_valid && (!held.chunk_end || out_free);

    sfc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .take       (step),
        .held_valid (held_valid),
        .held       (held)
    );

    sfc_frame_acc #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .beat  (held),
        .res   (res)
    );

    sfc_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && held.chunk_end),
        .res          (res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- sv/sfc_checker.sv -----
// ----------------------------------------------------------------------------
// Sensor frame checker port checker
// Watches the top level's ports for consistent frame reports.
// ----------------------------------------------------------------------------
`include "sensor_frame_checker_defines.svh"

module sfc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  result_valid,
    input logic                  result_ready,
    input sfc_pkg::result_beat_t result
);
    import sfc_pkg::*;

    `SFC_CHECK_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result beat changed")
    `SFC_CHECK(a_kind_code, result_valid, result.frame_kind != 2'd3, "frame kind out of range")
    `SFC_CHECK(a_none_invalid, result_valid && result.frame_kind == KIND_NONE, !result.frame_valid, "unknown frame marked valid")
    `SFC_CHECK(a_invalid_zero, result_valid && !result.frame_valid, result.co2_ppm == '0 && result.tvoc_ppb == '0 && result.hcho_ppb == '0 && result.pm25_value == '0, "invalid frame carries values")
    `SFC_CHECK(a_kind_fields, result_valid && result.frame_kind == KIND_GAS, result.pm25_value == '0, "gas frame carries particle value")

endmodule

bind sensor_frame_checker sfc_checker u_sfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
